// ----- rtl/mawm_pkg.sv -----
package mawm_pkg;

  localparam int WINDOW    = 10;
  localparam int SAMPLE_W  = 8;
  localparam int LIMIT_W   = 7;
  localparam int AVG_W     = 8;
  localparam int DAC_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Sum of WINDOW full-scale samples, fill count up to WINDOW, ring address.
  localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // The quotient always fits AVG_W bits, so the dividend is seen as
  // CNT_W high bits followed by AVG_W quotient bits.
  localparam int DIV_W  = CNT_W + AVG_W;
  localparam int STEP_W = $clog2(AVG_W);

  localparam logic [DAC_W-1:0] DAC_ABOVE = DAC_W'(4 * 51);
  localparam logic [DAC_W-1:0] DAC_BELOW = DAC_W'(2 * 51);
  localparam logic [DAC_W-1:0] DAC_MID   = DAC_W'(3 * 51);

  localparam logic [LIMIT_W-1:0] UPPER_RESET = LIMIT_W'(30);
  localparam logic [LIMIT_W-1:0] LOWER_RESET = LIMIT_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = CFG_IDX_W'(0),
    REG_LOWER = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

endpackage

// ----- rtl/mawm_ram.sv -----
module mawm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mawm_div.sv -----
module mawm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mawm_pkg::DIV_W-1:0] dividend,
  input  logic [mawm_pkg::CNT_W-1:0] divisor,
  output logic [mawm_pkg::AVG_W-1:0] quotient,
  output mawm_pkg::div_stat_t        stat
);
  import mawm_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [AVG_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic              last;

  // Restoring long division, one quotient bit per cycle, MSB first.
  assign trial = {rem_r, quo_r[AVG_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign last  = busy_r && (step_r == STEP_W'(AVG_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      busy_r <= !last;
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIV_W-1 -: CNT_W];
      quo_r <= dividend[AVG_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[AVG_W-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.last = last;

endmodule

// ----- rtl/moving_average_window_monitor_top.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_sample
// out       output     out_valid / out_stall out_average, out_*_flag, out_dac_level
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The ring entry being replaced is read in the cycle of the sample's beat. The update
// state writes the new sample, updates the sum and starts the divider; the divide state
// runs the bit-serial divider and then loads the output register. A new sample is
// taken only once the previous one has been loaded into the output register.
// Reset is synchronous and active low; the limits return to 30 and 20 and the
// ring reads as empty until it has been filled once.
// A stalled result holds in the output register while the next sample is
// processed; the last cycle waits only until that register is free.
module moving_average_window_monitor_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mawm_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mawm_pkg::AVG_W-1:0]     out_average,
  output logic                           out_above_flag,
  output logic                           out_below_flag,
  output logic                           out_inside_flag,
  output logic [mawm_pkg::DAC_W-1:0]     out_dac_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mawm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mawm_pkg::LIMIT_W-1:0]   cfg_data
);
  import mawm_pkg::*;

  state_t              state_r, state_nxt;
  logic [LIMIT_W-1:0]  upper_r, lower_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] ring_rdata, old_sample;
  logic                in_take;
  logic                ring_we;
  logic                div_start;
  logic                out_load;
  logic                out_free;
  logic [AVG_W-1:0]    quotient;
  div_stat_t           div_stat;
  logic                above, below, in_band;
  logic [DAC_W-1:0]    dac;

  logic                out_valid_r;
  logic [AVG_W-1:0]    avg_r;
  logic                above_r, below_r, inside_r;
  logic [DAC_W-1:0]    dac_r;

  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
      lower_r <= LOWER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UPPER: upper_r <= cfg_data;
        REG_LOWER: lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (!div_stat.busy && out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ring_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_UPDATE: begin
        ring_we   = 1'b1;
        div_start = 1'b1;
      end
      ST_DIVIDE: out_load = !div_stat.busy && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The ring fills in slot order, so an entry at or ahead of the write slot has
  // been written only once the fill count has reached the window.
  assign old_sample = (fill_r == CNT_W'(WINDOW)) ? ring_rdata : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
  assign fill_nxt   = (fill_r == CNT_W'(WINDOW)) ? fill_r : fill_r + CNT_W'(1);
  assign slot_nxt   = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
      slot_r <= '0;
    end else if (ring_we) begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_sample;
    end
  end

  mawm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  mawm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(sum_nxt)),
    .divisor  (fill_nxt),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign above   = quotient > AVG_W'(upper_r);
  assign below   = quotient < AVG_W'(lower_r);
  assign in_band = (quotient < AVG_W'(upper_r)) && (quotient > AVG_W'(lower_r));

  always_comb begin
    priority if (above) begin
      dac = DAC_ABOVE;
    end else if (below) begin
      dac = DAC_BELOW;
    end else begin
      dac = DAC_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_r    <= quotient;
      above_r  <= above;
      below_r  <= below;
      inside_r <= in_band;
      dac_r    <= dac;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = avg_r;
  assign out_above_flag  = above_r;
  assign out_below_flag  = below_r;
  assign out_inside_flag = inside_r;
  assign out_dac_level   = dac_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count ran past the window");

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    DIV_W'(sum_r) <= DIV_W'(fill_r) * DIV_W'((1 << SAMPLE_W) - 1))
    else $error("running sum exceeds what the stored samples allow");

  a_take_updates: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_UPDATE))
    else $error("accepted sample did not reach the update cycle");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.last |=> !div_stat.busy && (state_r == ST_DIVIDE))
    else $error("divider finished outside the divide phase");

endmodule
